// ----- sv/fbba_pkg.sv -----
// Shared types and constants for the free block bitmap allocator.
package fbba_pkg;

    localparam int unsigned DEF_MAX_BLOCKS    = 4096;
    localparam int unsigned DEF_MAP_WORD_BITS = 64;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned BLK_W  = 12;
    localparam int unsigned CNT_W  = 13;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 3;

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 13'd4096;

    localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEST  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND  = 2'd3;

    localparam logic [0:0] REG_BLOCK_COUNT = 1'b0;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [BLK_W-1:0] block_number;
    } t_in_item;

    typedef struct packed {
        logic             bit_value;
        logic [BLK_W-1:0] free_block;
        logic             none_free;
        logic             range_error;
    } t_out_item;

endpackage

// ----- sv/free_block_bitmap_allocator.sv -----
// Free block bitmap allocator: used-block bitmap with set, clear, test and first-fit find.
// Set/clear/test go through S_ADDR and S_RMW to S_DONE; out-of-range or zero count
// goes straight to S_DONE; find scans map words in S_SCAN (one word per cycle through the
// single bitmap memory read port, up to MAP_WORDS). One transaction in flight.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to all
// MAP_WORDS map words before the first transaction is taken.
module free_block_bitmap_allocator #(
    parameter int unsigned MAX_BLOCKS    = fbba_pkg::DEF_MAX_BLOCKS,
    parameter int unsigned MAP_WORD_BITS = fbba_pkg::DEF_MAP_WORD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fbba_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fbba_pkg::t_out_item             o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fbba_pkg::ADDR_W-1:0]     paddr,
    input  logic [fbba_pkg::DATA_W-1:0]     pwdata,
    output logic [fbba_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int unsigned MWB       = MAP_WORD_BITS;
    localparam int unsigned MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int unsigned WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned OFW       = $clog2(MAP_WORD_BITS);
    localparam int unsigned CW        = fbba_pkg::CNT_W;
    localparam int unsigned BW        = fbba_pkg::BLK_W;
    localparam int unsigned CNT_MAX   = (1 << CW) - 1;
    localparam int unsigned EFF_CAP   = (MAX_BLOCKS < CNT_MAX) ? MAX_BLOCKS : CNT_MAX;
    localparam int unsigned DIV_SH    = BW + 8;
    localparam int unsigned RECIP     = ((1 << DIV_SH) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int unsigned RCP_W     = DIV_SH - 2;
    localparam int unsigned PRD_W     = BW + RCP_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_RMW,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [1:0]          r_cmd, n_cmd;
    logic [BW-1:0]       r_blk, n_blk;
    logic [PRD_W-1:0]    r_prod, n_prod;
    logic [WAW-1:0]      r_widx, n_widx;
    logic [OFW-1:0]      r_off, n_off;
    logic [CW-1:0]       r_rem, n_rem;
    logic [CW-1:0]       r_base, n_base;
    fbba_pkg::t_out_item r_res, n_res;
    fbba_pkg::t_out_item r_out, n_out;
    logic                r_out_valid, n_out_valid;
    logic [CW-1:0]       r_count, n_count;

    logic [MWB-1:0]      mem [MAP_WORDS];
    logic [MWB-1:0]      r_rd;
    logic                mem_we;
    logic [WAW-1:0]      mem_waddr;
    logic [MWB-1:0]      mem_wdata;
    logic [WAW-1:0]      rd_addr;

    logic [CW-1:0]       eff_cnt;
    logic                out_free;
    logic                cfg_wr;
    logic [PRD_W-1:0]    q_full;
    logic [CW-1:0]       qm;
    logic [CW-1:0]       rem_full;
    logic [MWB-1:0]      bit_mask;
    logic                scan_found;
    logic [OFW-1:0]      scan_pos;
    logic [CW-1:0]       scan_blk;

    assign eff_cnt  = (r_count > CW'(EFF_CAP)) ? CW'(EFF_CAP) : r_count;
    assign out_free = !r_out_valid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite &&
                      (paddr[2:2] == fbba_pkg::REG_BLOCK_COUNT);
    assign q_full   = r_prod >> DIV_SH;
    assign qm       = CW'(q_full[BW-1:0] * MAP_WORD_BITS);
    assign rem_full = {1'b0, r_blk} - qm;
    assign bit_mask = MWB'(1) << (OFW'(MAP_WORD_BITS - 1) - r_off);
    assign scan_blk = r_base + CW'(scan_pos);

    // lowest free block in the current word; bits past the count read as used
    always_comb begin
        scan_found = 1'b0;
        scan_pos   = '0;
        for (int j = MWB - 1; j >= 0; j--) begin
            if (!r_rd[MWB-1-j] && (CW'(j) < r_rem)) begin
                scan_found = 1'b1;
                scan_pos   = OFW'(j);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_blk       = r_blk;
        n_prod      = r_prod;
        n_widx      = r_widx;
        n_off       = r_off;
        n_rem       = r_rem;
        n_base      = r_base;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_count     = cfg_wr ? pwdata[CW-1:0] : r_count;
        mem_we      = 1'b0;
        mem_waddr   = r_widx;
        mem_wdata   = '0;
        rd_addr     = r_widx;

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_widx == WAW'(MAP_WORDS - 1)) begin
                    n_widx  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_widx = r_widx + WAW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_in_data.command;
                    n_blk = i_in_data.block_number;
                    n_res = '0;
                    if (i_in_data.command == fbba_pkg::CMD_FIND) begin
                        if (eff_cnt == '0) begin
                            n_res.none_free = 1'b1;
                            n_state         = S_DONE;
                        end else begin
                            rd_addr = '0;
                            n_widx  = '0;
                            n_base  = '0;
                            n_rem   = eff_cnt;
                            n_state = S_SCAN;
                        end
                    end else if ({1'b0, i_in_data.block_number} >= eff_cnt) begin
                        n_res.range_error = 1'b1;
                        n_state           = S_DONE;
                    end else begin
                        n_prod  = PRD_W'(i_in_data.block_number * RECIP);
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                n_widx  = q_full[WAW-1:0];
                n_off   = rem_full[OFW-1:0];
                rd_addr = q_full[WAW-1:0];
                n_state = S_RMW;
            end
            S_RMW: begin
                case (r_cmd)
                    fbba_pkg::CMD_SET: begin
                        mem_we    = 1'b1;
                        mem_wdata = r_rd | bit_mask;
                    end
                    fbba_pkg::CMD_CLEAR: begin
                        mem_we    = 1'b1;
                        mem_wdata = r_rd & ~bit_mask;
                    end
                    fbba_pkg::CMD_TEST: begin
                        n_res.bit_value = |(r_rd & bit_mask);
                    end
                    default: begin
                    end
                endcase
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (scan_found) begin
                    n_res.free_block = scan_blk[BW-1:0];
                    n_state          = S_DONE;
                end else if (r_rem <= CW'(MAP_WORD_BITS)) begin
                    n_res.none_free = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    n_rem   = r_rem - CW'(MAP_WORD_BITS);
                    n_base  = r_base + CW'(MAP_WORD_BITS);
                    n_widx  = r_widx + WAW'(1);
                    rd_addr = r_widx + WAW'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_widx      <= '0;
            r_out_valid <= 1'b0;
            r_count     <= fbba_pkg::BLOCK_COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_widx      <= n_widx;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
        r_cmd  <= n_cmd;
        r_blk  <= n_blk;
        r_prod <= n_prod;
        r_off  <= n_off;
        r_rem  <= n_rem;
        r_base <= n_base;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[rd_addr];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2:2] == fbba_pkg::REG_BLOCK_COUNT) ?
                         {{(fbba_pkg::DATA_W - CW){1'b0}}, r_count} : '0;

endmodule

// ----- sv/fbba_checker.sv -----
// Port-level checks for the free block bitmap allocator, bound to the top level.
module fbba_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input fbba_pkg::t_out_item         o_out_data
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

    // one transaction in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again without a busy cycle");

    a_none_free_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.none_free) |->
        (o_out_data.free_block == '0 && !o_out_data.range_error &&
         !o_out_data.bit_value))
        else $error("none_free with other result fields set");

    a_range_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.range_error) |->
        (o_out_data.free_block == '0 && !o_out_data.bit_value))
        else $error("range_error with other result fields set");

endmodule

bind free_block_bitmap_allocator fbba_checker u_fbba_checker (.*);

// ----- tb/tb_free_block_bitmap_allocator.sv -----
// Self-checking testbench for the free block bitmap allocator.
module tb_free_block_bitmap_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS = fbba_pkg::DEF_MAP_WORD_BITS;
    localparam int MAP_WORDS = fbba_pkg::DEF_MAX_BLOCKS / fbba_pkg::DEF_MAP_WORD_BITS;
    localparam logic [fbba_pkg::ADDR_W-1:0] BLOCK_COUNT_ADDR =
        fbba_pkg::ADDR_W'(4 * fbba_pkg::REG_BLOCK_COUNT);
    localparam int NUM_PHASES = 10;
    localparam int PHASE_ITEMS = 54;

    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    fbba_pkg::t_in_item            i_in_data = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    fbba_pkg::t_out_item           o_out_data;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [fbba_pkg::ADDR_W-1:0]   paddr = '0;
    logic [fbba_pkg::DATA_W-1:0]   pwdata = '0;
    logic [fbba_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    fbba_pkg::t_in_item            cmd_queue[$];
    fbba_pkg::t_out_item           reply_queue[$];
    logic [WORD_BITS-1:0]          shadow_map[MAP_WORDS];
    logic [fbba_pkg::CNT_W-1:0]    cfg_count = fbba_pkg::BLOCK_COUNT_RESET;
    int                            fill_cursor = 0;
    int                            sender_idle_pct = 0;
    int                            stall_pct = 0;
    int                            mismatch_count = 0;
    int                            sent_count = 0;
    int                            reply_count = 0;
    int                            find_count = 0;
    int                            none_free_count = 0;
    int                            range_err_count = 0;
    int                            used_hit_count = 0;
    int unsigned                   phase_counts[NUM_PHASES] =
        '{8191, 1, 0, 100, 4097, 64, 65, 300, 2, 4096};

    free_block_bitmap_allocator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow bitmap update and expected reply for one command.
    function automatic fbba_pkg::t_out_item apply_bitmap_cmd(fbba_pkg::t_in_item it);
        fbba_pkg::t_out_item r;
        int lim;
        int w;
        int pos;
        bit found;
        r = '0;
        found = 1'b0;
        lim = (cfg_count > fbba_pkg::DEF_MAX_BLOCKS) ? fbba_pkg::DEF_MAX_BLOCKS :
              int'(cfg_count);
        if (it.command == fbba_pkg::CMD_FIND) begin
            for (int b = 0; b < lim && !found; b++) begin
                if (!shadow_map[b / WORD_BITS][WORD_BITS - 1 - b % WORD_BITS]) begin
                    r.free_block = fbba_pkg::BLK_W'(b);
                    found = 1'b1;
                end
            end
            r.none_free = !found;
        end else if (int'(it.block_number) >= lim) begin
            r.range_error = 1'b1;
        end else begin
            w = it.block_number / WORD_BITS;
            pos = WORD_BITS - 1 - it.block_number % WORD_BITS;
            case (it.command)
                fbba_pkg::CMD_SET: begin
                    shadow_map[w][pos] = 1'b1;
                end
                fbba_pkg::CMD_CLEAR: begin
                    shadow_map[w][pos] = 1'b0;
                end
                default: begin
                    r.bit_value = shadow_map[w][pos];
                end
            endcase
        end
        return r;
    endfunction

    // Mostly in-range traffic around the low blocks plus sequential allocation
    // from a cursor; a tenth is unconstrained noise.
    function automatic fbba_pkg::t_in_item random_cmd(int lim);
        fbba_pkg::t_in_item it;
        int r;
        int hot;
        r = $urandom_range(99);
        it.command = fbba_pkg::CMD_FIND;
        it.block_number = fbba_pkg::BLK_W'($urandom);
        if (r < 10) begin
            it.command = fbba_pkg::CMD_W'($urandom);
        end else if (r < 30 && lim > 0) begin
            if (fill_cursor >= lim) begin
                fill_cursor = 0;
            end
            it.command = fbba_pkg::CMD_SET;
            it.block_number = fbba_pkg::BLK_W'(fill_cursor);
            fill_cursor++;
        end else begin
            r = $urandom_range(99);
            it.command = (r < 35) ? fbba_pkg::CMD_SET :
                         (r < 55) ? fbba_pkg::CMD_CLEAR :
                         (r < 75) ? fbba_pkg::CMD_TEST : fbba_pkg::CMD_FIND;
            hot = (lim < 256) ? lim : 256;
            case ($urandom_range(9))
                0: begin
                    it.block_number = fbba_pkg::BLK_W'((lim > 4095) ? 4095 : lim);
                end
                1, 2: begin
                    if (lim > 0) it.block_number = fbba_pkg::BLK_W'($urandom_range(lim - 1));
                end
                default: begin
                    if (hot > 0) it.block_number = fbba_pkg::BLK_W'($urandom_range(hot - 1));
                end
            endcase
        end
        return it;
    endfunction

    task automatic push_cmd(logic [fbba_pkg::CMD_W-1:0] cmd, int blk);
        fbba_pkg::t_in_item it;
        it.command = cmd;
        it.block_number = fbba_pkg::BLK_W'(blk);
        cmd_queue.push_back(it);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (cmd_queue.size() != 0 || i_in_valid || reply_queue.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_block_count(logic [fbba_pkg::CNT_W-1:0] value);
        logic [fbba_pkg::DATA_W-1:0] rd;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BLOCK_COUNT_ADDR;
        pwdata  <= fbba_pkg::DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_count = value;
        // read back
        @(posedge i_clk);
        psel    <= 1'b1;
        paddr   <= BLOCK_COUNT_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rd = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[fbba_pkg::CNT_W-1:0] !== value) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("block_count readback: expected %0d got %0d",
                         value, rd[fbba_pkg::CNT_W-1:0]);
            end
        end
    endtask

    task automatic check_reply(fbba_pkg::t_out_item got);
        fbba_pkg::t_out_item want;
        reply_count++;
        if (got.none_free) none_free_count++;
        if (got.range_error) range_err_count++;
        if (got.bit_value) used_hit_count++;
        if (reply_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("unexpected transaction: bit %0d free %0d none %0d err %0d",
                         got.bit_value, got.free_block, got.none_free, got.range_error);
            end
            return;
        end
        want = reply_queue.pop_front();
        if (got.bit_value !== want.bit_value || got.free_block !== want.free_block ||
            got.none_free !== want.none_free || got.range_error !== want.range_error) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("mismatch at reply %0d: expected bit %0d free %0d none %0d err %0d",
                         reply_count, want.bit_value, want.free_block, want.none_free,
                         want.range_error);
                $display("                     got      bit %0d free %0d none %0d err %0d",
                         got.bit_value, got.free_block, got.none_free, got.range_error);
            end
        end
    endtask

    // Command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (i_in_data.command == fbba_pkg::CMD_FIND) find_count++;
                reply_queue.push_back(apply_bitmap_cmd(i_in_data));
                sent_count++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= cmd_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_reply(o_out_data);
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        for (int w = 0; w < MAP_WORDS; w++) begin
            shadow_map[w] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_cmd(fbba_pkg::CMD_FIND, 0);
        push_cmd(fbba_pkg::CMD_TEST, 0);
        push_cmd(fbba_pkg::CMD_SET, 0);
        push_cmd(fbba_pkg::CMD_TEST, 0);
        push_cmd(fbba_pkg::CMD_FIND, 4095);
        push_cmd(fbba_pkg::CMD_SET, 4095);
        push_cmd(fbba_pkg::CMD_TEST, 4095);
        push_cmd(fbba_pkg::CMD_CLEAR, 4095);
        push_cmd(fbba_pkg::CMD_TEST, 4095);
        push_cmd(fbba_pkg::CMD_SET, 63);
        push_cmd(fbba_pkg::CMD_SET, 64);
        push_cmd(fbba_pkg::CMD_TEST, 64);
        push_cmd(fbba_pkg::CMD_CLEAR, 0);
        push_cmd(fbba_pkg::CMD_FIND, 0);
        push_cmd(fbba_pkg::CMD_SET, 0);
        push_cmd(fbba_pkg::CMD_SET, 1);
        push_cmd(fbba_pkg::CMD_SET, 2);
        push_cmd(fbba_pkg::CMD_FIND, 0);
        push_cmd(fbba_pkg::CMD_TEST, 2048);
        push_cmd(fbba_pkg::CMD_CLEAR, 1);
        push_cmd(fbba_pkg::CMD_FIND, 0);
        push_cmd(fbba_pkg::CMD_SET, 1);
        push_cmd(fbba_pkg::CMD_SET, 1);
        push_cmd(fbba_pkg::CMD_CLEAR, 5);
        push_cmd(fbba_pkg::CMD_TEST, 1);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            repeat (4) @(posedge i_clk);
            write_block_count(fbba_pkg::CNT_W'(phase_counts[p]));
            case (p % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 58; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 58; end
                default: begin sender_idle_pct = 26; stall_pct = 26; end
            endcase
            for (int half = 0; half < 2; half++) begin
                for (int n = 0; n < PHASE_ITEMS / 2; n++) begin
                    cmd_queue.push_back(random_cmd(
                        (phase_counts[p] > fbba_pkg::DEF_MAX_BLOCKS) ?
                        fbba_pkg::DEF_MAX_BLOCKS : int'(phase_counts[p])));
                end
                // sender holds off until the block has answered everything
                wait_drained();
            end
        end

        repeat (80) @(posedge i_clk);
        if (reply_queue.size() != 0) begin
            mismatch_count += reply_queue.size();
            $display("%0d expected transactions never arrived", reply_queue.size());
        end
        $display("Ran %0d commands over %0d block_count settings, %0d mismatches.",
                 sent_count, NUM_PHASES + 1, mismatch_count);
        $display("Finds %0d (none free %0d), range errors %0d, used-bit hits %0d.",
                 find_count, none_free_count, range_err_count, used_hit_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d transactions outstanding", reply_queue.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/fbba_pkg.sv
sv/free_block_bitmap_allocator.sv
sv/fbba_checker.sv
tb/tb_free_block_bitmap_allocator.sv
